// File: hw/rtl/true_peak_detector_core_defines.svh
// assertion macros for the true peak detector checker
// expects clk and arst_n in the scope of each use
`ifndef TRUE_PEAK_DETECTOR_CORE_DEFINES_SVH
`define TRUE_PEAK_DETECTOR_CORE_DEFINES_SVH

// same-cycle implication, held off while reset is low
`define TPD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off while reset is low
`define TPD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/tpd_pkg.sv
// shared widths, controller states and command/status structs
// for the true peak detector; no dependencies
package tpd_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int PEAK_BITS   = SAMPLE_BITS + 1;
	localparam int DIFF_BITS   = SAMPLE_BITS + 1;
	localparam int E_BITS      = SAMPLE_BITS + 3;
	localparam int DIV_STEPS   = SAMPLE_BITS + 2;
	localparam int N_BITS      = DIV_STEPS;
	localparam int M_BITS      = SAMPLE_BITS + 4;
	localparam int R_BITS      = M_BITS + 2;
	localparam int Q_BITS      = SAMPLE_BITS + 1;
	localparam int V_BITS      = SAMPLE_BITS + 2;
	localparam int STEP_BITS   = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP1,
		ST_PREP2,
		ST_DIV,
		ST_ROUND,
		ST_APPLY,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic prep1;
		logic prep2;
		logic div_step;
		logic round;
		logic apply;
		logic finish;
		logic emit;
	} tpd_cmd_t;

	typedef struct packed {
		logic go;
		logic div_done;
		logic last;
	} tpd_status_t;

endpackage

// File: hw/rtl/tpd_ctrl.sv
// controller state machine for the true peak detector
// depends on tpd_pkg (states, command and status structs)
module tpd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	output logic                 peak_valid,
	input  logic                 peak_ready,
	input  tpd_pkg::tpd_status_t status,
	output tpd_pkg::tpd_cmd_t    cmd
);

	tpd_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic slot_free;

	assign slot_free  = !out_valid_q || peak_ready;
	assign peak_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (peak_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			tpd_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = tpd_pkg::ST_PREP1;
				end
			end
			tpd_pkg::ST_PREP1: begin
				cmd.prep1 = 1'b1;
				state_d   = tpd_pkg::ST_PREP2;
			end
			tpd_pkg::ST_PREP2: begin
				cmd.prep2 = 1'b1;
				state_d   = status.go ? tpd_pkg::ST_DIV : tpd_pkg::ST_FINISH;
			end
			tpd_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_done) begin
					state_d = tpd_pkg::ST_ROUND;
				end
			end
			tpd_pkg::ST_ROUND: begin
				cmd.round = 1'b1;
				state_d   = tpd_pkg::ST_APPLY;
			end
			tpd_pkg::ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = tpd_pkg::ST_FINISH;
			end
			tpd_pkg::ST_FINISH: begin
				// a last sample waits here until the output slot is free
				if (!status.last || slot_free) begin
					cmd.finish = 1'b1;
					cmd.emit   = status.last;
					state_d    = tpd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tpd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: hw/rtl/tpd_datapath.sv
// datapath of the true peak detector: sample history, running peak,
// parabolic term via shift-subtract divider; depends on tpd_pkg
module tpd_datapath (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  tpd_pkg::tpd_cmd_t                       cmd,
	input  logic signed [tpd_pkg::SAMPLE_BITS-1:0]  sample,
	input  logic                                    last,
	output tpd_pkg::tpd_status_t                    status,
	output logic        [tpd_pkg::PEAK_BITS-1:0]    peak
);

	localparam int SB = tpd_pkg::SAMPLE_BITS;
	localparam int PB = tpd_pkg::PEAK_BITS;
	localparam int AW = tpd_pkg::DIFF_BITS;
	localparam int EW = tpd_pkg::E_BITS;
	localparam int NW = tpd_pkg::N_BITS;
	localparam int MW = tpd_pkg::M_BITS;
	localparam int RW = tpd_pkg::R_BITS;
	localparam int QW = tpd_pkg::Q_BITS;
	localparam int VW = tpd_pkg::V_BITS;
	localparam int CW = tpd_pkg::STEP_BITS;

	// request and history
	logic signed [SB-1:0] y_q, prev_q, older_q;
	logic                 last_q;
	logic [1:0]           fill_q;
	logic [PB-1:0]        peak_q, interp_q, peak_out_q;

	// triple analysis
	logic signed [AW-1:0] a_q;
	logic signed [EW-1:0] e_q;
	logic                 is_max_q, is_min_q;

	// divider
	logic [NW-1:0] n_q;
	logic [MW-1:0] m_q;
	logic [MW-1:0] r_q;
	logic [QW-1:0] q_q, c_q;
	logic [CW-1:0] cnt_q;

	logic signed [AW-1:0] y_ext, a_w;
	logic signed [EW-1:0] e_w;
	logic [PB-1:0]        mag_y;
	logic [AW-1:0]        n_w;
	logic [EW-1:0]        em_w;
	logic                 go_w;
	logic [RW-1:0]        r2_w, m1_w, m2_w;
	logic                 ge1_w, ge2_w;
	logic [RW-1:0]        rn_w;
	logic [1:0]           digit_w;
	logic                 round_up_w;
	logic signed [VW-1:0] v_w;
	logic [VW-1:0]        vmag_w;
	logic [PB-1:0]        vsat_w, pk_w;

	// first analysis step: differences, extremum flags, sample magnitude
	assign y_ext = AW'(y_q);
	assign a_w   = AW'(older_q) - AW'(y_q);
	assign e_w   = EW'(older_q) + EW'(y_q) - (EW'(prev_q) <<< 1);
	assign mag_y = y_ext[AW-1] ? PB'(-y_ext) : PB'(y_ext);

	// second step: go needs a full triple, a strict extremum, e != 0 and |d| < 1, i.e. |a| < 2|e|
	assign n_w  = a_q[AW-1] ? AW'(-a_q) : AW'(a_q);
	assign em_w = e_q[EW-1] ? EW'(-e_q) : EW'(e_q);
	assign go_w = (fill_q == 2'd2) && (is_max_q || is_min_q) && (em_w != '0)
		&& ((EW + 1)'(n_w) < {em_w, 1'b0});

	// one bit of n*n/m per cycle, quotient digit 0..2
	assign r2_w    = RW'({r_q, 1'b0}) + (n_q[cnt_q] ? RW'(n_q) : '0);
	assign m1_w    = RW'(m_q);
	assign m2_w    = RW'({m_q, 1'b0});
	assign ge1_w   = r2_w >= m1_w;
	assign ge2_w   = r2_w >= m2_w;
	assign rn_w    = ge2_w ? (r2_w - m2_w) : (ge1_w ? (r2_w - m1_w) : r2_w);
	assign digit_w = ge2_w ? 2'd2 : (ge1_w ? 2'd1 : 2'd0);

	// round to nearest, halves up
	assign round_up_w = (MW + 1)'({r_q, 1'b0}) >= (MW + 1)'(m_q);

	// interpolated value: add at a maximum, subtract at a minimum
	assign v_w    = is_max_q ? (VW'(prev_q) + $signed({1'b0, c_q}))
		: (VW'(prev_q) - $signed({1'b0, c_q}));
	assign vmag_w = v_w[VW-1] ? VW'(-v_w) : VW'(v_w);
	assign vsat_w = (|vmag_w[VW-1:PB]) ? '1 : vmag_w[PB-1:0];

	assign pk_w = (interp_q > peak_q) ? interp_q : peak_q;

	assign status.go       = go_w;
	assign status.div_done = (cnt_q == '0);
	assign status.last     = last_q;
	assign peak            = peak_out_q;

	// history and running peak
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			older_q <= '0;
			fill_q  <= 2'd0;
			peak_q  <= '0;
		end else if (cmd.prep1) begin
			if (mag_y > peak_q) begin
				peak_q <= mag_y;
			end
		end else if (cmd.finish) begin
			if (last_q) begin
				prev_q  <= '0;
				older_q <= '0;
				fill_q  <= 2'd0;
				peak_q  <= '0;
			end else begin
				peak_q  <= pk_w;
				older_q <= prev_q;
				prev_q  <= y_q;
				if (fill_q != 2'd2) begin
					fill_q <= fill_q + 2'd1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			y_q    <= sample;
			last_q <= last;
		end
		if (cmd.prep1) begin
			a_q      <= a_w;
			e_q      <= e_w;
			is_max_q <= (prev_q > older_q) && (prev_q > y_q);
			is_min_q <= (prev_q < older_q) && (prev_q < y_q);
			interp_q <= '0;
		end
		if (cmd.prep2) begin
			n_q   <= NW'(n_w);
			m_q   <= {em_w[MW-4:0], 3'b000};
			r_q   <= '0;
			q_q   <= '0;
			cnt_q <= CW'(tpd_pkg::DIV_STEPS - 1);
		end
		if (cmd.div_step) begin
			r_q   <= rn_w[MW-1:0];
			q_q   <= {q_q[QW-2:0], 1'b0} + QW'(digit_w);
			cnt_q <= cnt_q - CW'(1);
		end
		if (cmd.round) begin
			c_q <= q_q + QW'(round_up_w);
		end
		if (cmd.apply) begin
			interp_q <= vsat_w;
		end
		if (cmd.emit) begin
			peak_out_q <= pk_w;
		end
	end

endmodule

// File: hw/rtl/true_peak_detector_core.sv
// true peak detector: one sample per request, result on the last sample
// a sample that completes a full triple with a strict extremum in the middle
// (and passes go) runs the 26-step shift-subtract divider of the parabolic term
// peak_valid is registered and rises once a last sample retires from ST_FINISH
// a result waiting on peak_ready does not hold off the next sample request
// arst_n low clears history, running peak and the output valid at once
module true_peak_detector_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   item_valid,
	output logic                                   item_ready,
	input  logic signed [tpd_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                   last,
	output logic                                   peak_valid,
	input  logic                                   peak_ready,
	output logic        [tpd_pkg::PEAK_BITS-1:0]   peak
);

	// command and status between the sequencer and the datapath
	tpd_pkg::tpd_cmd_t    cmd;
	tpd_pkg::tpd_status_t status;

	// sequencer: accept, analyze the triple, run the divider, retire
	tpd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.peak_valid (peak_valid),
		.peak_ready (peak_ready),
		.status     (status),
		.cmd        (cmd)
	);

	// datapath: history, running maximum, interpolation and output register
	tpd_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sample (sample),
		.last   (last),
		.status (status),
		.peak   (peak)
	);

endmodule

// File: hw/rtl/tpd_checker.sv
// port-level checks on the true peak detector, bound to the top level
// depends on tpd_pkg and true_peak_detector_core_defines.svh
`include "true_peak_detector_core_defines.svh"

module tpd_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             item_valid,
	input logic                             item_ready,
	input logic                             last,
	input logic                             peak_valid,
	input logic                             peak_ready,
	input logic [tpd_pkg::PEAK_BITS-1:0]    peak
);

	`TPD_ASSERT_NXT(a_peak_hold, peak_valid && !peak_ready, peak_valid, "peak dropped while stalled")
	`TPD_ASSERT_NXT(a_peak_stable, peak_valid && !peak_ready, $stable(peak), "peak changed while stalled")
	`TPD_ASSERT_NXT(a_one_at_a_time, item_valid && item_ready, !item_ready, "second sample taken while busy")
	`TPD_ASSERT_NXT(a_no_early_result, item_valid && item_ready && !last, !$rose(peak_valid), "result without last sample")

endmodule

bind true_peak_detector_core tpd_checker u_tpd_checker (.*);
